FILE: rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Field widths
    localparam int ELEM_W   = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;

    // Default number of cells
    localparam int QUEUE_DEPTH_DEF = 16;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // One queue entry
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [PRIO_W-1:0] priority_val;
    } entry_t;

    // What a cell loads on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_LOAD_LEFT,
        CELL_LOAD_RIGHT
    } cell_cmd_t;

    // Control handed from the chain controller to each cell
    typedef struct packed {
        cell_cmd_t cmd;
        logic      occupied;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, flags whether a new entry
// belongs at or ahead of it, and loads from the new beat or a neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire logic               aclk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::entry_t    new_entry,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    yield
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Yield the slot when it is empty or holds a priority at or above the new one
    assign yield = !ctrl.occupied || (entry_reg.priority_val >= new_entry.priority_val);

    // Select the next contents
    always_comb begin
        case (ctrl.cmd)
            CELL_LOAD_NEW:   entry_next = new_entry;
            CELL_LOAD_LEFT:  entry_next = left_entry;
            CELL_LOAD_RIGHT: entry_next = right_entry;
            default:         entry_next = entry_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted row of cells.
// ---------------------------------------------------------------------------
// Each beat on the s_ side is an insert or a delete and produces exactly one
// result beat on the m_ side in the next cycle. The queue is a row of
// QUEUE_DEPTH cells kept in ascending priority order; every cell decides in
// the same cycle whether to hold, take the new entry or take a neighbor's
// entry, so inserts and deletes update the whole row at once; a new beat is
// taken every cycle while the result register drains. The front cell always
// holds the smallest priority; among equal priorities the newest leaves
// first. Insert into a full queue returns overflow, delete from an empty one
// returns underflow with zero element and priority; neither changes the
// queue. Cell contents are not reset; only the entry count and m_valid are.
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [spq_pkg::ELEM_W-1:0]    s_element,
    input  wire logic [spq_pkg::PRIO_W-1:0]    s_priority_req,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [spq_pkg::ELEM_W-1:0]         m_out_element,
    output logic [spq_pkg::PRIO_W-1:0]         m_out_priority,
    output logic [spq_pkg::STATUS_W-1:0]       m_status,
    output logic [CNT_W-1:0]                   m_entries_held
);
    import spq_pkg::*;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg;
    logic [ELEM_W-1:0]   out_element_reg, out_element_next;
    logic [PRIO_W-1:0]   out_priority_reg, out_priority_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic       accept;
    logic       full;
    logic       empty;
    logic       do_insert;
    logic       do_delete;
    entry_t     new_entry;
    entry_t     cell_q   [QUEUE_DEPTH];
    logic       yield    [QUEUE_DEPTH];
    cell_ctrl_t ctrl     [QUEUE_DEPTH];

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_insert = accept && (s_operation == OP_INSERT) && !full;
    assign do_delete = accept && (s_operation == OP_DELETE) && !empty;

    assign new_entry.element      = s_element;
    assign new_entry.priority_val = s_priority_req;

    // Build the cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        // Decide each cell's move from its own and its left neighbor's yield
        always_comb begin
            ctrl[i].occupied = (CNT_W'(i) < count_reg);
            ctrl[i].cmd      = CELL_HOLD;
            if (do_insert) begin
                if (i > 0 && yield[(i > 0) ? i - 1 : 0]) begin
                    ctrl[i].cmd = CELL_LOAD_LEFT;
                end else if (yield[i]) begin
                    ctrl[i].cmd = CELL_LOAD_NEW;
                end
            end else if (do_delete) begin
                ctrl[i].cmd = CELL_LOAD_RIGHT;
            end
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl[i]),
            .new_entry   (new_entry),
            .left_entry  (cell_q[(i > 0) ? i - 1 : 0]),
            .right_entry (cell_q[(i < QUEUE_DEPTH - 1) ? i + 1 : QUEUE_DEPTH - 1]),
            .entry       (cell_q[i]),
            .yield       (yield[i])
        );
    end

    // Form the result beat and the new count
    always_comb begin
        count_next        = count_reg;
        out_element_next  = '0;
        out_priority_next = '0;
        status_next       = ST_DONE;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_delete) begin
            count_next        = count_reg - CNT_W'(1);
            out_element_next  = cell_q[0].element;
            out_priority_next = cell_q[0].priority_val;
        end else if (s_operation == OP_INSERT) begin
            status_next = ST_OVERFLOW;
        end else begin
            status_next = ST_UNDERFLOW;
        end
    end

    // Hold count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            out_element_reg  <= out_element_next;
            out_priority_reg <= out_priority_next;
            status_reg       <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_element  = out_element_reg;
    assign m_out_priority = out_priority_reg;
    assign m_status       = status_reg;
    assign m_entries_held = count_reg;

`ifndef ASSERT_OFF
    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    // Front two cells stay in priority order
    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_q[0].priority_val <= cell_q[1].priority_val))
        else $error("front cells out of order");

    // A rejected beat leaves the count unchanged
    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !do_insert && !do_delete) |=> $stable(count_reg))
        else $error("count moved on rejected beat");

    // Underflow reports carry zero payload
    a_underflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_UNDERFLOW) |-> (m_out_element == '0 && m_out_priority == '0))
        else $error("underflow with nonzero payload");
`endif

endmodule

`default_nettype wire
